FILE: design/ps2s2k_pkg.sv
// Shared constants for the PS/2 set-1 scancode to key decoder.
`timescale 1ns / 1ps
`default_nettype none
package ps2s2k_pkg;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned TableAw    = $clog2(TableDepth);

  // Input opcodes
  localparam logic [1:0] OpScan      = 2'd0;
  localparam logic [1:0] OpWrNormal  = 2'd1;
  localparam logic [1:0] OpWrShift   = 2'd2;
  localparam logic [1:0] OpWrAltgr   = 2'd3;

  // Configuration register indexes
  localparam logic [0:0] CfgLayoutSize  = 1'd0;
  localparam logic [0:0] CfgAltgrEnable = 1'd1;

  // Scancode bytes and key codes
  localparam logic [7:0] PrefixByte = 8'hE0;
  localparam logic [6:0] KeyLShift  = 7'h2A;
  localparam logic [6:0] KeyRShift  = 7'h36;
  localparam logic [6:0] KeyCaps    = 7'h3A;
  localparam logic [6:0] XKeyRAlt   = 7'h38;
  localparam logic [6:0] XKeyLeft   = 7'h4B;
  localparam logic [6:0] XKeyRight  = 7'h4D;
  localparam logic [6:0] XKeyUp     = 7'h48;
  localparam logic [6:0] XKeyDown   = 7'h50;
  localparam logic [6:0] XKeyDel    = 7'h53;
  localparam logic [6:0] XKeyPgUp   = 7'h49;
  localparam logic [6:0] XKeyPgDown = 7'h51;

  // Result kinds
  localparam logic KindChar    = 1'b0;
  localparam logic KindSpecial = 1'b1;

  // Special codes
  localparam logic [7:0] SpLeft     = 8'd0;
  localparam logic [7:0] SpRight    = 8'd1;
  localparam logic [7:0] SpUp       = 8'd2;
  localparam logic [7:0] SpDown     = 8'd3;
  localparam logic [7:0] SpScrollUp = 8'd4;
  localparam logic [7:0] SpScrollDn = 8'd5;
  localparam logic [7:0] SpDelete   = 8'd6;
  localparam logic [7:0] SpPgUp     = 8'd7;
  localparam logic [7:0] SpPgDown   = 8'd8;

  localparam logic [7:0] LayoutSizeReset = 8'd128;

endpackage
`default_nettype wire

FILE: design/ps2s2k_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ps2s2k_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: design/ps2s2k_scancode_to_key_unit.sv
// Character selection and caps-lock case fix for the PS/2 decoder.
`timescale 1ns / 1ps
`default_nettype none
module ps2s2k_char_fix (
  input  wire logic       caps_i,
  input  wire logic       shift_i,
  input  wire logic       altgr_i,
  input  wire logic [7:0] normal_i,
  input  wire logic [7:0] shifted_i,
  input  wire logic [7:0] altgr_char_i,
  output logic      [7:0] char_o
);

  logic [7:0] base;

  always_comb begin
    base = shift_i ? shifted_i : normal_i;
    if (altgr_i && (altgr_char_i != 8'd0)) begin
      char_o = altgr_char_i;
    end else if (caps_i && !shift_i && (base >= 8'h61) && (base <= 8'h7A)) begin
      char_o = base ^ 8'h20;   // lower to upper
    end else if (caps_i && shift_i && (base >= 8'h41) && (base <= 8'h5A)) begin
      char_o = base ^ 8'h20;   // upper to lower
    end else begin
      char_o = base;
    end
  end

endmodule
`default_nettype wire

FILE: design/ps2_scancode_to_key_unit.sv
// Top level of the PS/2 set-1 scancode to key decoder.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per scancode
//   byte (opcode 0) or per layout table write (opcodes 1..3 for the normal,
//   shifted and AltGr tables). Output channel (out_valid_o / out_stall_i)
//   carries zero or one beat per input beat: a character (kind 0) or a
//   special navigation code (kind 1). Breaks, prefixes, modifier keys,
//   table writes and zero characters give no output beat.
//   Stages: table RAM read and lookup stage, then the output register.
//   Throughput: one beat per cycle unless the receiver stalls, set by the
//   single read port of each table RAM; a table write lands in time for a
//   lookup in the next cycle.
//   Reset clears the modifier flags, the prefix flag and all pipeline valid
//   bits; layout_size returns to 128 and altgr_enable to 0. The tables are
//   not cleared and must be loaded before use.
//   When the receiver stalls, the output beat and the lookup stage's RAM data
//   hold, and if the lookup stage is empty one more input beat is still taken
//   before in_stall_o rises. The user must write the configuration port only
//   while the block is idle; the block itself does not enforce this.
module ps2_scancode_to_key_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration write port
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  // Input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] scan_byte_i,
  input  wire logic [6:0] table_index_i,
  input  wire logic [7:0] table_char_i,
  // Output channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            kind_o,
  output logic [7:0]      code_o
);

  // Configuration registers
  logic [7:0] layout_size_q;
  logic       altgr_enable_q;

  // Keyboard flags
  logic shift_q, shift_d;
  logic caps_q, caps_d;
  logic altgr_q, altgr_d;
  logic prefix_q, prefix_d;

  // Lookup stage: holds the decoded beat while the RAM read completes
  logic       s1_valid_q, s1_valid_d;
  logic       s1_lookup_q, s1_lookup_d;   // needs a table translation
  logic [7:0] s1_code_q, s1_code_d;       // special code when not a lookup
  logic       s1_shift_q, s1_caps_q, s1_altgr_q;

  // Output register
  logic       out_valid_q;
  logic       out_kind_q;
  logic [7:0] out_code_q;

  logic       accept;
  logic       s1_adv;
  logic [6:0] key;
  logic       brk;
  logic [7:0] nm_rdata, sh_rdata, ag_rdata;
  logic [7:0] xlat_char;
  logic       s1_emit;

  assign key = scan_byte_i[6:0];
  assign brk = scan_byte_i[7];

  // Advance the lookup stage whenever the output register is free or drains.
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_size_q  <= ps2s2k_pkg::LayoutSizeReset;
      altgr_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ps2s2k_pkg::CfgLayoutSize:  layout_size_q  <= cfg_data_i;
        ps2s2k_pkg::CfgAltgrEnable: altgr_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Decode the scancode byte, update flags and choose what the lookup
  // stage will do with it.
  always_comb begin
    shift_d     = shift_q;
    caps_d      = caps_q;
    altgr_d     = altgr_q;
    prefix_d    = prefix_q;
    s1_valid_d  = 1'b0;
    s1_lookup_d = 1'b0;
    s1_code_d   = ps2s2k_pkg::SpLeft;
    if (opcode_i == ps2s2k_pkg::OpScan) begin
      if (scan_byte_i == ps2s2k_pkg::PrefixByte) begin
        prefix_d = 1'b1;
      end else if (prefix_q) begin
        // Extended key: the prefix covers only this byte
        prefix_d = 1'b0;
        if (brk) begin
          if (key == ps2s2k_pkg::XKeyRAlt) begin
            altgr_d = 1'b0;
          end
        end else begin
          s1_valid_d = 1'b1;
          case (key)
            ps2s2k_pkg::XKeyLeft:   s1_code_d = ps2s2k_pkg::SpLeft;
            ps2s2k_pkg::XKeyRight:  s1_code_d = ps2s2k_pkg::SpRight;
            ps2s2k_pkg::XKeyUp:
              s1_code_d = shift_q ? ps2s2k_pkg::SpScrollUp : ps2s2k_pkg::SpUp;
            ps2s2k_pkg::XKeyDown:
              s1_code_d = shift_q ? ps2s2k_pkg::SpScrollDn : ps2s2k_pkg::SpDown;
            ps2s2k_pkg::XKeyDel:    s1_code_d = ps2s2k_pkg::SpDelete;
            ps2s2k_pkg::XKeyPgUp:   s1_code_d = ps2s2k_pkg::SpPgUp;
            ps2s2k_pkg::XKeyPgDown: s1_code_d = ps2s2k_pkg::SpPgDown;
            ps2s2k_pkg::XKeyRAlt: begin
              altgr_d    = 1'b1;
              s1_valid_d = 1'b0;
            end
            default: s1_valid_d = 1'b0;
          endcase
        end
      end else if ((key == ps2s2k_pkg::KeyLShift) || (key == ps2s2k_pkg::KeyRShift)) begin
        shift_d = !brk;
      end else if ((key == ps2s2k_pkg::KeyCaps) && !brk) begin
        caps_d = !caps_q;
      end else if (!brk && ({1'b0, key} < layout_size_q)) begin
        // Ordinary make: translate through the tables next cycle
        s1_valid_d  = 1'b1;
        s1_lookup_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
      altgr_q  <= 1'b0;
      prefix_q <= 1'b0;
    end else if (accept) begin
      shift_q  <= shift_d;
      caps_q   <= caps_d;
      altgr_q  <= altgr_d;
      prefix_q <= prefix_d;
    end
  end

  // Lookup stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= s1_valid_d;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Snapshot the flags the translation needs; hold them with the RAM data.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_lookup_q <= s1_lookup_d;
      s1_code_q   <= s1_code_d;
      s1_shift_q  <= shift_q;
      s1_caps_q   <= caps_q;
      s1_altgr_q  <= altgr_q && altgr_enable_q;
    end
  end

  // Layout tables: written by table beats, read by every accepted beat
  ps2s2k_ram #(
    .WIDTH(8),
    .DEPTH(ps2s2k_pkg::TableDepth)
  ) u_normal_ram (
    .clk_i  (clk_i),
    .we_i   (accept && (opcode_i == ps2s2k_pkg::OpWrNormal)),
    .waddr_i(table_index_i[ps2s2k_pkg::TableAw-1:0]),
    .wdata_i(table_char_i),
    .re_i   (accept),
    .raddr_i(key[ps2s2k_pkg::TableAw-1:0]),
    .rdata_o(nm_rdata)
  );

  ps2s2k_ram #(
    .WIDTH(8),
    .DEPTH(ps2s2k_pkg::TableDepth)
  ) u_shifted_ram (
    .clk_i  (clk_i),
    .we_i   (accept && (opcode_i == ps2s2k_pkg::OpWrShift)),
    .waddr_i(table_index_i[ps2s2k_pkg::TableAw-1:0]),
    .wdata_i(table_char_i),
    .re_i   (accept),
    .raddr_i(key[ps2s2k_pkg::TableAw-1:0]),
    .rdata_o(sh_rdata)
  );

  ps2s2k_ram #(
    .WIDTH(8),
    .DEPTH(ps2s2k_pkg::TableDepth)
  ) u_altgr_ram (
    .clk_i  (clk_i),
    .we_i   (accept && (opcode_i == ps2s2k_pkg::OpWrAltgr)),
    .waddr_i(table_index_i[ps2s2k_pkg::TableAw-1:0]),
    .wdata_i(table_char_i),
    .re_i   (accept),
    .raddr_i(key[ps2s2k_pkg::TableAw-1:0]),
    .rdata_o(ag_rdata)
  );

  // Pick the table entry and apply caps lock
  ps2s2k_char_fix u_char_fix (
    .caps_i      (s1_caps_q),
    .shift_i     (s1_shift_q),
    .altgr_i     (s1_altgr_q),
    .normal_i    (nm_rdata),
    .shifted_i   (sh_rdata),
    .altgr_char_i(ag_rdata),
    .char_o      (xlat_char)
  );

  // Drop a translation that comes out as zero
  assign s1_emit = s1_valid_q && (!s1_lookup_q || (xlat_char != 8'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_kind_q <= s1_lookup_q ? ps2s2k_pkg::KindChar : ps2s2k_pkg::KindSpecial;
      out_code_q <= s1_lookup_q ? xlat_char : s1_code_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign code_o      = out_code_q;

endmodule
`default_nettype wire
